// ----- rtl/core/mtef_pkg.sv -----
// ----------------------------------------------------------------------------
// MACD filter package
// Shared widths, register indexes, reset values and the control-store
// program of the MACD filter's microcoded sequencer.
// ----------------------------------------------------------------------------
package mtef_pkg;

  // Field widths of the stream items and configuration registers.
  localparam int PRICE_W     = 32;
  localparam int LINE_W      = 33;
  localparam int HIST_W      = 34;
  localparam int PERIOD_W    = 8;
  localparam int ALPHA_W     = 17;
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 1;
  localparam int OUT_TDATA_W = 104;
  localparam int OUT_TUSER_W = 2;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 17;

  // Default depth of the sample counters.
  localparam int PERIOD_MAX_DEF = 255;

  // Datapath widths of the smoothing update.
  localparam int TAVG_W = HIST_W;          // trigger average
  localparam int D_W    = 35;              // difference sample - average
  localparam int MUL_W  = 18;              // signed multiplier operand
  localparam int PROD_W = 2 * MUL_W;       // multiplier product
  localparam int LO_W   = D_W - MUL_W;     // low slice of the difference
  localparam int ACC_W  = PROD_W + LO_W;   // recombined product
  localparam int FRAC_W = 16;              // Q1.16 alpha fraction
  localparam int STEP_W = ACC_W - FRAC_W;  // average increment

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_FAST_PERIOD   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SLOW_PERIOD   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SIGNAL_PERIOD = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_FAST_ALPHA    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SLOW_ALPHA    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_SIGNAL_ALPHA  = 3'd5;

  // Register values after reset.
  localparam logic [PERIOD_W-1:0] FAST_PERIOD_RST   = 8'd12;
  localparam logic [PERIOD_W-1:0] SLOW_PERIOD_RST   = 8'd26;
  localparam logic [PERIOD_W-1:0] SIGNAL_PERIOD_RST = 8'd9;
  localparam logic [ALPHA_W-1:0]  FAST_ALPHA_RST    = 17'd10082;
  localparam logic [ALPHA_W-1:0]  SLOW_ALPHA_RST    = 17'd4855;
  localparam logic [ALPHA_W-1:0]  SIGNAL_ALPHA_RST  = 17'd13107;

  // Control word fields.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_START,    // take the sample: restart clear and sample count
    OP_SEED,     // add to the seed sum of the channel
    OP_DIV,      // start the seed mean division
    OP_SET,      // store the seed mean, mark the channel seeded
    OP_DIFF,     // difference to the average, pick alpha
    OP_MUL_HI,   // multiply upper slice of the difference
    OP_MUL_LO,   // move upper product, multiply lower slice
    OP_ACC,      // add both partial products
    OP_EMA,      // add the scaled difference to the average
    OP_MACD,     // fast minus slow
    OP_EMIT      // load the result register
  } op_t;

  typedef enum logic [1:0] {
    CH_FAST,
    CH_SLOW,
    CH_TRIG
  } chan_t;

  typedef enum logic [2:0] {
    C_NEXT,      // fall through
    C_ALWAYS,
    C_NO_INPUT,  // no sample transfer this cycle
    C_READY,     // channel already seeded
    C_NOT_DUE,   // channel count below its period
    C_DIV_BUSY,
    C_NO_LINE,   // fast or slow not seeded
    C_OUT_FULL   // result register still occupied
  } cond_t;

  localparam int PC_W = 6;

  typedef struct packed {
    op_t              op;
    chan_t            ch;
    cond_t            cond;
    logic [PC_W-1:0]  target;
  } uword_t;

  // Program addresses that are jump targets.
  localparam logic [PC_W-1:0] S_IDLE   = 6'd0;
  localparam logic [PC_W-1:0] S_F_WAIT = 6'd6;
  localparam logic [PC_W-1:0] S_F_EMA  = 6'd8;
  localparam logic [PC_W-1:0] S_SLOW   = 6'd13;
  localparam logic [PC_W-1:0] S_S_WAIT = 6'd17;
  localparam logic [PC_W-1:0] S_S_EMA  = 6'd19;
  localparam logic [PC_W-1:0] S_LINE   = 6'd24;
  localparam logic [PC_W-1:0] S_T_WAIT = 6'd29;
  localparam logic [PC_W-1:0] S_T_EMA  = 6'd31;
  localparam logic [PC_W-1:0] S_OUT    = 6'd36;

  function automatic uword_t mk_word(input op_t op, input chan_t ch, input cond_t cond,
                                     input logic [PC_W-1:0] target);
    uword_t w;
    w.op     = op;
    w.ch     = ch;
    w.cond   = cond;
    w.target = target;
    return w;
  endfunction

  // Control store: one word per step.
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      // Wait for a sample, then take it.
      6'd0:  w = mk_word(OP_NOP,    CH_FAST, C_NO_INPUT, S_IDLE);
      6'd1:  w = mk_word(OP_START,  CH_FAST, C_NEXT,     S_IDLE);
      // Fast average.
      6'd2:  w = mk_word(OP_NOP,    CH_FAST, C_READY,    S_F_EMA);
      6'd3:  w = mk_word(OP_SEED,   CH_FAST, C_NEXT,     S_IDLE);
      6'd4:  w = mk_word(OP_NOP,    CH_FAST, C_NOT_DUE,  S_SLOW);
      6'd5:  w = mk_word(OP_DIV,    CH_FAST, C_NEXT,     S_IDLE);
      6'd6:  w = mk_word(OP_NOP,    CH_FAST, C_DIV_BUSY, S_F_WAIT);
      6'd7:  w = mk_word(OP_SET,    CH_FAST, C_ALWAYS,   S_SLOW);
      6'd8:  w = mk_word(OP_DIFF,   CH_FAST, C_NEXT,     S_IDLE);
      6'd9:  w = mk_word(OP_MUL_HI, CH_FAST, C_NEXT,     S_IDLE);
      6'd10: w = mk_word(OP_MUL_LO, CH_FAST, C_NEXT,     S_IDLE);
      6'd11: w = mk_word(OP_ACC,    CH_FAST, C_NEXT,     S_IDLE);
      6'd12: w = mk_word(OP_EMA,    CH_FAST, C_NEXT,     S_IDLE);
      // Slow average.
      6'd13: w = mk_word(OP_NOP,    CH_SLOW, C_READY,    S_S_EMA);
      6'd14: w = mk_word(OP_SEED,   CH_SLOW, C_NEXT,     S_IDLE);
      6'd15: w = mk_word(OP_NOP,    CH_SLOW, C_NOT_DUE,  S_LINE);
      6'd16: w = mk_word(OP_DIV,    CH_SLOW, C_NEXT,     S_IDLE);
      6'd17: w = mk_word(OP_NOP,    CH_SLOW, C_DIV_BUSY, S_S_WAIT);
      6'd18: w = mk_word(OP_SET,    CH_SLOW, C_ALWAYS,   S_LINE);
      6'd19: w = mk_word(OP_DIFF,   CH_SLOW, C_NEXT,     S_IDLE);
      6'd20: w = mk_word(OP_MUL_HI, CH_SLOW, C_NEXT,     S_IDLE);
      6'd21: w = mk_word(OP_MUL_LO, CH_SLOW, C_NEXT,     S_IDLE);
      6'd22: w = mk_word(OP_ACC,    CH_SLOW, C_NEXT,     S_IDLE);
      6'd23: w = mk_word(OP_EMA,    CH_SLOW, C_NEXT,     S_IDLE);
      // MACD line and trigger average.
      6'd24: w = mk_word(OP_NOP,    CH_TRIG, C_NO_LINE,  S_OUT);
      6'd25: w = mk_word(OP_MACD,   CH_TRIG, C_READY,    S_T_EMA);
      6'd26: w = mk_word(OP_SEED,   CH_TRIG, C_NEXT,     S_IDLE);
      6'd27: w = mk_word(OP_NOP,    CH_TRIG, C_NOT_DUE,  S_OUT);
      6'd28: w = mk_word(OP_DIV,    CH_TRIG, C_NEXT,     S_IDLE);
      6'd29: w = mk_word(OP_NOP,    CH_TRIG, C_DIV_BUSY, S_T_WAIT);
      6'd30: w = mk_word(OP_SET,    CH_TRIG, C_ALWAYS,   S_OUT);
      6'd31: w = mk_word(OP_DIFF,   CH_TRIG, C_NEXT,     S_IDLE);
      6'd32: w = mk_word(OP_MUL_HI, CH_TRIG, C_NEXT,     S_IDLE);
      6'd33: w = mk_word(OP_MUL_LO, CH_TRIG, C_NEXT,     S_IDLE);
      6'd34: w = mk_word(OP_ACC,    CH_TRIG, C_NEXT,     S_IDLE);
      6'd35: w = mk_word(OP_EMA,    CH_TRIG, C_NEXT,     S_IDLE);
      // Hand over the result.
      6'd36: w = mk_word(OP_NOP,    CH_FAST, C_OUT_FULL, S_OUT);
      6'd37: w = mk_word(OP_EMIT,   CH_FAST, C_ALWAYS,   S_IDLE);
      default: w = mk_word(OP_NOP,  CH_FAST, C_ALWAYS,   S_IDLE);
    endcase
    return w;
  endfunction

  // Alpha values above 1.0 act as 1.0.
  function automatic logic [ALPHA_W-1:0] eff_alpha(input logic [ALPHA_W-1:0] a);
    return (a > ALPHA_ONE) ? ALPHA_ONE : a;
  endfunction

endpackage

// ----- rtl/core/macd_triple_ema_filter.sv -----
// ----------------------------------------------------------------------------
// MACD triple moving average filter
// Fast, slow and trigger exponential averages over a price stream, run by a
// microcoded sequencer over one shared multiplier and one serial divider.
// ----------------------------------------------------------------------------
// Each price sample yields one result. Once every average is seeded, each of
// the three average updates takes five steps of the control program and
// shares one 18 by 18 multiplier. A sample that completes a seed adds a
// serial mean division for each average that it seeds. The next sample is
// taken while the previous result still waits on the output.
module macd_triple_ema_filter #(
  parameter int PERIOD_MAX = mtef_pkg::PERIOD_MAX_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // Price samples.
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [mtef_pkg::IN_TDATA_W-1:0]    s_tdata,   // price[31:0]
  input  logic [mtef_pkg::IN_TUSER_W-1:0]    s_tuser,   // restart
  // Results.
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // macd_line[32:0], trigger_line[65:33], histogram[99:66], zero pad
  output logic [mtef_pkg::OUT_TDATA_W-1:0]   m_tdata,
  // line_valid, trigger_valid
  output logic [mtef_pkg::OUT_TUSER_W-1:0]   m_tuser,
  // Configuration writes.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mtef_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [mtef_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int CNT_W   = $clog2(PERIOD_MAX + 2);
  localparam int SUM_W   = mtef_pkg::PRICE_W + CNT_W;
  localparam int TSUM_W  = mtef_pkg::HIST_W + CNT_W;
  localparam int DIV_W   = TSUM_W - 1;
  localparam int PRICE_W = mtef_pkg::PRICE_W;
  localparam int LINE_W  = mtef_pkg::LINE_W;
  localparam int HIST_W  = mtef_pkg::HIST_W;
  localparam int TAVG_W  = mtef_pkg::TAVG_W;
  localparam int D_W     = mtef_pkg::D_W;
  localparam int MUL_W   = mtef_pkg::MUL_W;
  localparam int PROD_W  = mtef_pkg::PROD_W;
  localparam int LO_W    = mtef_pkg::LO_W;
  localparam int ACC_W   = mtef_pkg::ACC_W;
  localparam int STEP_W  = mtef_pkg::STEP_W;
  localparam int ALPHA_W = mtef_pkg::ALPHA_W;

  // Periods of zero act as one, above the counter depth as the depth.
  function automatic logic [CNT_W-1:0] eff_period(input logic [mtef_pkg::PERIOD_W-1:0] p);
    logic [CNT_W-1:0] r;
    if (p == '0) begin
      r = CNT_W'(1);
    end else if (int'(p) > PERIOD_MAX) begin
      r = CNT_W'(PERIOD_MAX);
    end else begin
      r = CNT_W'(p);
    end
    return r;
  endfunction

  // Configuration registers.
  logic [mtef_pkg::PERIOD_W-1:0] fast_period, slow_period, signal_period;
  logic [ALPHA_W-1:0]            fast_alpha, slow_alpha, signal_alpha;

  // Sequencer.
  logic [mtef_pkg::PC_W-1:0] pc, pc_next;
  mtef_pkg::uword_t          uw;
  logic                      take;

  // Filter state.
  logic [CNT_W-1:0]         sample_count, macd_count;
  logic [SUM_W-1:0]         fast_seed_sum, slow_seed_sum;
  logic signed [TSUM_W-1:0] trigger_seed_sum;
  logic [PRICE_W-1:0]       fast_average, slow_average;
  logic signed [TAVG_W-1:0] trigger_average;
  logic                     fast_seeded, slow_seeded, trig_seeded;

  // Working registers.
  logic [PRICE_W-1:0]       price;
  logic                     restart;
  logic signed [LINE_W-1:0] macd;
  logic signed [D_W-1:0]    diff;
  logic [ALPHA_W-1:0]       alpha;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic                     div_neg;

  // Result register.
  logic                     out_full;
  logic                     out_line_ok, out_trig_ok;
  logic signed [LINE_W-1:0] out_macd, out_trig;
  logic signed [HIST_W-1:0] out_hist;

  // Combinational helpers.
  logic                     in_xfer;
  logic                     ch_ready, ch_not_due, line_ok;
  logic                     div_start, div_busy;
  logic [DIV_W-1:0]         div_dividend, div_quotient;
  logic [CNT_W-1:0]         div_divisor;
  logic signed [TSUM_W-1:0] tsum_mag;
  logic signed [TAVG_W-1:0] tq;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [STEP_W-1:0] ema_inc, ema_base, ema_sum;
  logic [CNT_W-1:0]         count_inc, mcount_inc;

  assign uw        = mtef_pkg::ucode(pc);
  assign s_tready  = (pc == mtef_pkg::S_IDLE);
  assign in_xfer   = s_tvalid & s_tready;
  assign cfg_ready = 1'b1;
  assign line_ok   = fast_seeded & slow_seeded;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      fast_period   <= mtef_pkg::FAST_PERIOD_RST;
      slow_period   <= mtef_pkg::SLOW_PERIOD_RST;
      signal_period <= mtef_pkg::SIGNAL_PERIOD_RST;
      fast_alpha    <= mtef_pkg::FAST_ALPHA_RST;
      slow_alpha    <= mtef_pkg::SLOW_ALPHA_RST;
      signal_alpha  <= mtef_pkg::SIGNAL_ALPHA_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mtef_pkg::CFG_FAST_PERIOD:   fast_period   <= cfg_data[mtef_pkg::PERIOD_W-1:0];
        mtef_pkg::CFG_SLOW_PERIOD:   slow_period   <= cfg_data[mtef_pkg::PERIOD_W-1:0];
        mtef_pkg::CFG_SIGNAL_PERIOD: signal_period <= cfg_data[mtef_pkg::PERIOD_W-1:0];
        mtef_pkg::CFG_FAST_ALPHA:    fast_alpha    <= cfg_data;
        mtef_pkg::CFG_SLOW_ALPHA:    slow_alpha    <= cfg_data;
        mtef_pkg::CFG_SIGNAL_ALPHA:  signal_alpha  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Channel status for the jump conditions.
  always_comb begin
    unique case (uw.ch)
      mtef_pkg::CH_FAST: begin
        ch_ready   = fast_seeded;
        ch_not_due = sample_count < eff_period(fast_period);
      end
      mtef_pkg::CH_SLOW: begin
        ch_ready   = slow_seeded;
        ch_not_due = sample_count < eff_period(slow_period);
      end
      mtef_pkg::CH_TRIG: begin
        ch_ready   = trig_seeded;
        ch_not_due = macd_count < eff_period(signal_period);
      end
      default: begin
        ch_ready   = 1'b0;
        ch_not_due = 1'b0;
      end
    endcase
  end

  // Jump decision and step counter.
  always_comb begin
    unique case (uw.cond)
      mtef_pkg::C_NEXT:     take = 1'b0;
      mtef_pkg::C_ALWAYS:   take = 1'b1;
      mtef_pkg::C_NO_INPUT: take = ~in_xfer;
      mtef_pkg::C_READY:    take = ch_ready;
      mtef_pkg::C_NOT_DUE:  take = ch_not_due;
      mtef_pkg::C_DIV_BUSY: take = div_busy;
      mtef_pkg::C_NO_LINE:  take = ~line_ok;
      mtef_pkg::C_OUT_FULL: take = out_full;
      default:              take = 1'b0;
    endcase
    pc_next = take ? uw.target : pc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= mtef_pkg::S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  // Seed mean division: prices are unsigned, the trigger seed is signed.
  always_comb begin
    tsum_mag  = trigger_seed_sum[TSUM_W-1] ? -trigger_seed_sum : trigger_seed_sum;
    div_start = (uw.op == mtef_pkg::OP_DIV);
    unique case (uw.ch)
      mtef_pkg::CH_FAST: begin
        div_dividend = DIV_W'(fast_seed_sum);
        div_divisor  = sample_count;
      end
      mtef_pkg::CH_SLOW: begin
        div_dividend = DIV_W'(slow_seed_sum);
        div_divisor  = sample_count;
      end
      mtef_pkg::CH_TRIG: begin
        div_dividend = tsum_mag[DIV_W-1:0];
        div_divisor  = macd_count;
      end
      default: begin
        div_dividend = '0;
        div_divisor  = CNT_W'(1);
      end
    endcase
    tq = div_neg ? -TAVG_W'(div_quotient) : TAVG_W'(div_quotient);
  end

  mtef_div #(
    .DIVIDEND_W (DIV_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quotient)
  );

  // Shared multiplier: the difference is split into a signed upper slice and
  // an unsigned lower slice, each multiplied by alpha in its own step.
  always_comb begin
    if (uw.op == mtef_pkg::OP_MUL_HI) begin
      mul_a = diff[D_W-1:LO_W];
    end else begin
      mul_a = $signed({1'b0, diff[LO_W-1:0]});
    end
    mul_b = $signed({1'b0, alpha});
    mul_p = mul_a * mul_b;
  end

  // Average update: the arithmetic shift rounds toward minus infinity.
  always_comb begin
    ema_inc = acc[ACC_W-1:mtef_pkg::FRAC_W];
    unique case (uw.ch)
      mtef_pkg::CH_FAST: ema_base = $signed({{(STEP_W-PRICE_W){1'b0}}, fast_average});
      mtef_pkg::CH_SLOW: ema_base = $signed({{(STEP_W-PRICE_W){1'b0}}, slow_average});
      mtef_pkg::CH_TRIG: ema_base = STEP_W'(trigger_average);
      default:           ema_base = '0;
    endcase
    ema_sum = ema_base + ema_inc;
  end

  // Counters saturate one past the depth.
  always_comb begin
    count_inc  = (sample_count <= CNT_W'(PERIOD_MAX)) ? sample_count + 1'b1 : sample_count;
    mcount_inc = (macd_count <= CNT_W'(PERIOD_MAX)) ? macd_count + 1'b1 : macd_count;
  end

  // Filter state, cleared by reset and by a restart sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count     <= '0;
      macd_count       <= '0;
      fast_seed_sum    <= '0;
      slow_seed_sum    <= '0;
      trigger_seed_sum <= '0;
      fast_average     <= '0;
      slow_average     <= '0;
      trigger_average  <= '0;
      fast_seeded      <= 1'b0;
      slow_seeded      <= 1'b0;
      trig_seeded      <= 1'b0;
    end else begin
      unique case (uw.op)
        mtef_pkg::OP_START: begin
          if (restart) begin
            sample_count     <= CNT_W'(1);
            macd_count       <= '0;
            fast_seed_sum    <= '0;
            slow_seed_sum    <= '0;
            trigger_seed_sum <= '0;
            fast_average     <= '0;
            slow_average     <= '0;
            trigger_average  <= '0;
            fast_seeded      <= 1'b0;
            slow_seeded      <= 1'b0;
            trig_seeded      <= 1'b0;
          end else begin
            sample_count <= count_inc;
          end
        end
        mtef_pkg::OP_SEED: begin
          unique case (uw.ch)
            mtef_pkg::CH_FAST: fast_seed_sum <= fast_seed_sum + SUM_W'(price);
            mtef_pkg::CH_SLOW: slow_seed_sum <= slow_seed_sum + SUM_W'(price);
            mtef_pkg::CH_TRIG: begin
              macd_count       <= mcount_inc;
              trigger_seed_sum <= trigger_seed_sum + TSUM_W'(macd);
            end
            default: ;
          endcase
        end
        mtef_pkg::OP_SET: begin
          unique case (uw.ch)
            mtef_pkg::CH_FAST: begin
              fast_average <= div_quotient[PRICE_W-1:0];
              fast_seeded  <= 1'b1;
            end
            mtef_pkg::CH_SLOW: begin
              slow_average <= div_quotient[PRICE_W-1:0];
              slow_seeded  <= 1'b1;
            end
            mtef_pkg::CH_TRIG: begin
              trigger_average <= tq;
              trig_seeded     <= 1'b1;
            end
            default: ;
          endcase
        end
        mtef_pkg::OP_EMA: begin
          unique case (uw.ch)
            mtef_pkg::CH_FAST: fast_average    <= ema_sum[PRICE_W-1:0];
            mtef_pkg::CH_SLOW: slow_average    <= ema_sum[PRICE_W-1:0];
            mtef_pkg::CH_TRIG: trigger_average <= ema_sum[TAVG_W-1:0];
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // Working registers of the datapath.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      price   <= s_tdata;
      restart <= s_tuser[0];
    end
    unique case (uw.op)
      mtef_pkg::OP_DIV: begin
        div_neg <= (uw.ch == mtef_pkg::CH_TRIG) && trigger_seed_sum[TSUM_W-1];
      end
      mtef_pkg::OP_DIFF: begin
        unique case (uw.ch)
          mtef_pkg::CH_FAST: begin
            diff  <= $signed({3'b000, price}) - $signed({3'b000, fast_average});
            alpha <= mtef_pkg::eff_alpha(fast_alpha);
          end
          mtef_pkg::CH_SLOW: begin
            diff  <= $signed({3'b000, price}) - $signed({3'b000, slow_average});
            alpha <= mtef_pkg::eff_alpha(slow_alpha);
          end
          mtef_pkg::CH_TRIG: begin
            diff  <= D_W'(macd) - D_W'(trigger_average);
            alpha <= mtef_pkg::eff_alpha(signal_alpha);
          end
          default: ;
        endcase
      end
      mtef_pkg::OP_MUL_HI: prod <= mul_p;
      mtef_pkg::OP_MUL_LO: begin
        acc  <= {prod, {LO_W{1'b0}}};
        prod <= mul_p;
      end
      mtef_pkg::OP_ACC:  acc  <= acc + ACC_W'(prod);
      mtef_pkg::OP_MACD: macd <= $signed({1'b0, fast_average}) - $signed({1'b0, slow_average});
      default: ;
    endcase
  end

  // Result register; fields stay zero until their averages are seeded.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (uw.op == mtef_pkg::OP_EMIT) begin
      out_full <= 1'b1;
    end else if (m_tvalid && m_tready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.op == mtef_pkg::OP_EMIT) begin
      out_line_ok <= line_ok;
      out_trig_ok <= line_ok & trig_seeded;
      out_macd    <= line_ok ? macd : '0;
      out_trig    <= (line_ok && trig_seeded) ? trigger_average[LINE_W-1:0] : '0;
      out_hist    <= (line_ok && trig_seeded) ? HIST_W'(macd) - trigger_average : '0;
    end
  end

  assign m_tvalid = out_full;
  assign m_tdata  = {{(mtef_pkg::OUT_TDATA_W - LINE_W - LINE_W - HIST_W){1'b0}},
                     out_hist, out_trig, out_macd};
  assign m_tuser  = {out_trig_ok, out_line_ok};

endmodule

// ----- rtl/core/mtef_div.sv -----
// ----------------------------------------------------------------------------
// MACD filter seed divider
// Restoring unsigned divider, one quotient bit per clock.
// ----------------------------------------------------------------------------
module mtef_div #(
  parameter int DIVIDEND_W = 41,
  parameter int DIVISOR_W  = 9
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  busy,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int STEP_CNT_W = $clog2(DIVIDEND_W + 1);

  logic [STEP_CNT_W-1:0] steps;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvsr;
  logic [DIVIDEND_W-1:0] q;
  logic [DIVISOR_W:0]    trial;
  logic                  ge;
  logic [DIVISOR_W:0]    trial_sub;

  // Shift the next dividend bit into the partial remainder and compare.
  always_comb begin
    trial     = {rem, q[DIVIDEND_W-1]};
    ge        = (trial >= {1'b0, dvsr});
    trial_sub = trial - {1'b0, dvsr};
  end

  // Step counter and busy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      steps <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      steps <= STEP_CNT_W'(DIVIDEND_W);
    end else if (busy) begin
      steps <= steps - 1'b1;
      if (steps == STEP_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      q    <= dividend;
      dvsr <= divisor;
    end else if (busy) begin
      rem <= ge ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      q   <= {q[DIVIDEND_W-2:0], ge};
    end
  end

  assign quotient = q;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MACD triple moving average filter testbench
// Sends price samples through the input stream and checks every result
// against an in-bench model of the fast, slow and trigger averages. The run
// goes through directed corner cases, then random price series under several
// register settings, with random idle cycles on both stream sides.
// ----------------------------------------------------------------------------
module tb_top;
  import mtef_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 200;
  localparam int PRINT_LIMIT  = 40;
  localparam int COUNT_MAX    = 255;  // sample counters stop one past this

  // Indexes outside the register map; writes to them must change nothing.
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic              line_ok;
    logic [LINE_W-1:0] macd;
    logic              trig_ok;
    logic [LINE_W-1:0] trig;
    logic [HIST_W-1:0] hist;
  } macd_result_t;

  // Clock and reset.
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Stream and configuration signals.
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata   = '0;
  logic [IN_TUSER_W-1:0]  s_tuser   = '0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [OUT_TUSER_W-1:0] m_tuser;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  macd_triple_ema_filter dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Idle percentages of the two stream sides.
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  int mismatch_count = 0;
  int results_seen   = 0;
  int cycle_count    = 0;

  // Results still owed by the block, oldest first.
  macd_result_t macd_due[$];

  // Register copy, indexed by channel.
  logic [PERIOD_W-1:0] len_reg  [3];
  logic [ALPHA_W-1:0]  gain_reg [3];

  // Series state of the model.
  int          n_samples;
  int          n_macd;
  logic [63:0] seed_sum   [2];
  longint      price_avg  [2];
  bit          price_seeded [2];
  longint      trig_sum;
  longint      trig_avg;
  bit          trig_seeded;

  function automatic void clear_series();
    n_samples = 0;
    n_macd    = 0;
    for (int c = 0; c < 2; c++) begin
      seed_sum[c]     = '0;
      price_avg[c]    = 0;
      price_seeded[c] = 1'b0;
    end
    trig_sum    = 0;
    trig_avg    = 0;
    trig_seeded = 1'b0;
  endfunction

  function automatic void reset_model();
    len_reg[CH_FAST]  = FAST_PERIOD_RST;
    len_reg[CH_SLOW]  = SLOW_PERIOD_RST;
    len_reg[CH_TRIG]  = SIGNAL_PERIOD_RST;
    gain_reg[CH_FAST] = FAST_ALPHA_RST;
    gain_reg[CH_SLOW] = SLOW_ALPHA_RST;
    gain_reg[CH_TRIG] = SIGNAL_ALPHA_RST;
    clear_series();
  endfunction

  // A zero period counts as one.
  function automatic int seed_len(input chan_t ch);
    return (len_reg[ch] == '0) ? 1 : int'(len_reg[ch]);
  endfunction

  // One smoothing step; the arithmetic shift floors the scaled difference.
  function automatic longint smooth(input longint avg, input longint x, input chan_t ch);
    longint a;
    a = (gain_reg[ch] > ALPHA_ONE) ? 64'sd65536 : longint'(gain_reg[ch]);
    return avg + (((x - avg) * a) >>> 16);
  endfunction

  // Fast or slow average: collect the seed, then smooth.
  function automatic void track_price(input chan_t ch, input longint x);
    if (price_seeded[ch]) begin
      price_avg[ch] = smooth(price_avg[ch], x, ch);
    end else begin
      seed_sum[ch] = seed_sum[ch] + 64'(x);
      if (n_samples >= seed_len(ch)) begin
        price_avg[ch]    = longint'(seed_sum[ch] / 64'(n_samples));
        price_seeded[ch] = 1'b1;
      end
    end
  endfunction

  // Advance the model by one sample and return the result it owes.
  function automatic macd_result_t macd_step(input logic [PRICE_W-1:0] price,
                                             input logic restart);
    macd_result_t r;
    longint       x;
    longint       macd;
    r = '0;
    x = longint'(price);
    if (restart) clear_series();
    if (n_samples <= COUNT_MAX) n_samples++;
    track_price(CH_FAST, x);
    track_price(CH_SLOW, x);
    if (price_seeded[CH_FAST] && price_seeded[CH_SLOW]) begin
      macd = price_avg[CH_FAST] - price_avg[CH_SLOW];
      if (trig_seeded) begin
        trig_avg = smooth(trig_avg, macd, CH_TRIG);
      end else begin
        if (n_macd <= COUNT_MAX) n_macd++;
        trig_sum = trig_sum + macd;
        // Signed division truncates toward zero.
        if (n_macd >= seed_len(CH_TRIG)) begin
          trig_avg    = trig_sum / longint'(n_macd);
          trig_seeded = 1'b1;
        end
      end
      r.line_ok = 1'b1;
      r.macd    = LINE_W'(macd);
      if (trig_seeded) begin
        r.trig_ok = 1'b1;
        r.trig    = LINE_W'(trig_avg);
        r.hist    = HIST_W'(macd - trig_avg);
      end
    end
    return r;
  endfunction

  task automatic log_mismatch(input string msg);
    if (mismatch_count < PRINT_LIMIT) $display("[%0t] %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(input string name, input logic [HIST_W-1:0] got,
                               input logic [HIST_W-1:0] want);
    if (got !== want) begin
      log_mismatch($sformatf("result %0d: %s is %h, expected %h",
                             results_seen, name, got, want));
    end
  endtask

  // Receiver stalls.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Check each result transfer against the oldest owed result.
  always @(posedge clk) begin
    macd_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (macd_due.size() == 0) begin
        log_mismatch($sformatf("result with no sample pending: tuser %b tdata %h",
                               m_tuser, m_tdata));
      end else begin
        want = macd_due.pop_front();
        compare_field("line_valid", HIST_W'(m_tuser[0]), HIST_W'(want.line_ok));
        compare_field("trigger_valid", HIST_W'(m_tuser[1]), HIST_W'(want.trig_ok));
        compare_field("macd_line", HIST_W'(m_tdata[LINE_W-1:0]), HIST_W'(want.macd));
        compare_field("trigger_line", HIST_W'(m_tdata[2*LINE_W-1:LINE_W]),
                      HIST_W'(want.trig));
        compare_field("histogram", m_tdata[2*LINE_W+HIST_W-1:2*LINE_W], want.hist);
      end
      results_seen++;
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // One sample transfer; tvalid stays high so the next sample can follow at once.
  task automatic send_sample(input logic [PRICE_W-1:0] price, input logic restart);
    int gap;
    gap = 0;
    if ($urandom_range(99) < tx_idle_pct) gap = $urandom_range(30, 1);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= price;
    s_tuser  <= restart;
    do @(posedge clk); while (!s_tready);
    macd_due.push_back(macd_step(price, restart));
  endtask

  // Stop sending and wait until every owed result has come back.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (macd_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // One register write transfer; the caller lowers cfg_valid after the last one.
  task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (index)
      CFG_FAST_PERIOD:   len_reg[CH_FAST]  = data[PERIOD_W-1:0];
      CFG_SLOW_PERIOD:   len_reg[CH_SLOW]  = data[PERIOD_W-1:0];
      CFG_SIGNAL_PERIOD: len_reg[CH_TRIG]  = data[PERIOD_W-1:0];
      CFG_FAST_ALPHA:    gain_reg[CH_FAST] = data;
      CFG_SLOW_ALPHA:    gain_reg[CH_SLOW] = data;
      CFG_SIGNAL_ALPHA:  gain_reg[CH_TRIG] = data;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [CFG_DATA_W-1:0] fast_len,
                                input logic [CFG_DATA_W-1:0] slow_len,
                                input logic [CFG_DATA_W-1:0] trig_len,
                                input logic [CFG_DATA_W-1:0] fast_gain,
                                input logic [CFG_DATA_W-1:0] slow_gain,
                                input logic [CFG_DATA_W-1:0] trig_gain);
    wait_idle();
    write_register(CFG_FAST_PERIOD, fast_len);
    write_register(CFG_SLOW_PERIOD, slow_len);
    write_register(CFG_SIGNAL_PERIOD, trig_len);
    write_register(CFG_FAST_ALPHA, fast_gain);
    write_register(CFG_SLOW_ALPHA, slow_gain);
    write_register(CFG_SIGNAL_ALPHA, trig_gain);
    cfg_valid <= 1'b0;
  endtask

  // Period word with junk in the bits above the period field.
  function automatic logic [CFG_DATA_W-1:0] period_word(input int len);
    return {9'($urandom_range(511)), 8'(len)};
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    case ($urandom_range(4))
      0:       return '0;
      1:       return ALPHA_ONE;
      2:       return '1;
      3:       return CFG_DATA_W'($urandom_range(65536));
      default: return CFG_DATA_W'($urandom());
    endcase
  endfunction

  // Random price series: each opens with a restart, prices mostly drift
  // around a level, with a few wild samples and stray restarts.
  task automatic run_series_mix(input int item_count, input int run_min, input int run_max);
    int                 left;
    logic [PRICE_W-1:0] level;
    logic [PRICE_W-1:0] price;
    logic               restart;
    left  = 0;
    level = '0;
    for (int i = 0; i < item_count; i++) begin
      restart = 1'b0;
      if (left == 0) begin
        left    = $urandom_range(run_max, run_min);
        level   = $urandom();
        restart = 1'b1;
      end else if ($urandom_range(99) < 3) begin
        restart = 1'b1;
      end
      left--;
      if ($urandom_range(9) < 8) begin
        level = level + PRICE_W'($urandom_range(2097152)) - 32'd1048576;
        price = level;
      end else begin
        price = $urandom();
      end
      send_sample(price, restart);
    end
  endtask

  // Reset registers: nothing seeded yet, so every value field is zero.
  task automatic test_not_ready_outputs();
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b1);
  endtask

  // Full-scale price swings with alpha at one, at zero and above one. The
  // trigger seed sum is negative and odd, so its mean truncates toward zero.
  task automatic test_extreme_prices();
    wait_idle();
    write_register(CFG_SPARE_LO, '1);
    write_register(CFG_SPARE_HI, 17'h0_0001);
    cfg_valid <= 1'b0;
    apply_settings(1, 3, 2, ALPHA_ONE, 0, 17'h1_FFFF);
    send_sample(32'hFFFF_FFFF, 1'b1);
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'h0000_0001, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0);
    send_sample(32'h0000_0000, 1'b0);
  endtask

  // Fast period above slow, and a zero signal period.
  task automatic test_fast_above_slow();
    apply_settings(4, 2, 0, 100, 40000, 65535);
    send_sample(32'h1234_5678, 1'b1);
    send_sample(32'hFFFF_0000, 1'b0);
    send_sample(32'h0000_FFFF, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
  endtask

  // Periods lowered below the samples already collected: seeding happens
  // on the next sample with the mean of everything collected.
  task automatic test_period_lowered();
    apply_settings(255, 255, 1, 30000, 20000, 40000);
    send_sample(32'h0100_0000, 1'b1);
    send_sample(32'h0300_0000, 1'b0);
    send_sample(32'h0200_0007, 1'b0);
    send_sample(32'h0400_0000, 1'b0);
    apply_settings(2, 1, 1, 30000, 20000, 40000);
    send_sample(32'h0500_0003, 1'b0);
    send_sample(32'h0100_0000, 1'b0);
  endtask

  task automatic test_default_settings();
    apply_settings(FAST_PERIOD_RST, SLOW_PERIOD_RST, SIGNAL_PERIOD_RST,
                   FAST_ALPHA_RST, SLOW_ALPHA_RST, SIGNAL_ALPHA_RST);
    run_series_mix(100, 20, 80);
  endtask

  task automatic test_random_settings();
    for (int k = 0; k < 3; k++) begin
      apply_settings(period_word($urandom_range(12)), period_word($urandom_range(12)),
                     period_word($urandom_range(8)), pick_gain(), pick_gain(), pick_gain());
      run_series_mix(35, 4, 30);
    end
  endtask

  // Longest trigger seed period, over one series of 262 samples that may hold stray restarts.
  task automatic test_long_trigger_seed();
    apply_settings(1, 1, 255, 20000, 9000, 3000);
    run_series_mix(262, 262, 262);
  endtask

  initial begin
    reset_model();
    tx_idle_pct = 28;
    rx_idle_pct = 82;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_not_ready_outputs();
    test_extreme_prices();
    test_fast_above_slow();
    test_period_lowered();
    test_default_settings();

    tx_idle_pct = 82;
    rx_idle_pct = 28;
    test_random_settings();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_long_trigger_seed();

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
